@@ rtl/psc_pkg.sv @@
// psc_pkg: shared types and pipeline depths for the parabolic sine/cosine unit
// no dependencies; imported by the channel interfaces and every module

package psc_pkg;

  localparam int WRAP_STAGES  = 6;
  localparam int CURVE_STAGES = 9;
  localparam int STAGES       = WRAP_STAGES + CURVE_STAGES;

  localparam int ANGLE_W = 32;
  localparam int RAD_W   = 23;
  localparam int TRIG_W  = 16;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [RAD_W-1:0]   rad_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

endpackage

@@ rtl/psc_in_if.sv @@
// psc_in_if: valid/ready channel carrying one angle item
// depends on psc_pkg

interface psc_in_if import psc_pkg::*; ();

  logic   valid;
  logic   ready;
  angle_t angle_deg;

  modport source (output valid, output angle_deg, input ready);
  modport sink (input valid, input angle_deg, output ready);

endinterface

@@ rtl/psc_out_if.sv @@
// psc_out_if: valid/ready channel carrying one sine/cosine item
// depends on psc_pkg

interface psc_out_if import psc_pkg::*; ();

  logic  valid;
  logic  ready;
  trig_t sine;
  trig_t cosine;

  modport source (output valid, output sine, output cosine, input ready);
  modport sink (input valid, input sine, input cosine, output ready);

endinterface

@@ rtl/psc_wrap.sv @@
// psc_wrap: six-stage front end, degrees q16.16 to wrapped radians q3.20
// gives the sine argument and the cosine argument (shifted by pi/2)
// depends on psc_pkg

module psc_wrap import psc_pkg::*; (
  input  logic                   clk,
  input  logic [WRAP_STAGES-1:0] en,
  input  angle_t                 angle_deg,
  output rad_t                   x_sin,
  output rad_t                   x_cos
);

  // floor(a / 360deg) = floor(floor(a / 2^19) / 45)
  localparam logic [13:0]        RECIP_45  = 14'd11651;
  localparam logic [13:0]        TURN_45   = 14'd45;
  localparam logic [13:0]        BIAS_LO   = 14'd44;
  localparam logic signed [33:0] TURN_BIAS = 34'sd2170552320;
  localparam logic [24:0]        DEG180    = 25'd11796480;
  localparam logic signed [25:0] DEG360    = 26'sd23592960;
  localparam logic signed [27:0] DEG2RAD   = 28'sd74961321;
  localparam logic signed [53:0] HALF28    = 54'sd134217728;
  localparam logic signed [23:0] HALF_PI   = 24'sd1647099;
  localparam logic signed [23:0] PI_Q20    = 24'sd3294199;
  localparam logic signed [23:0] TWO_PI    = 24'sd6588398;

  // stage 0: turn count estimate
  logic [13:0] u;
  logic [27:0] qm;
  logic [7:0]  s0_q;
  angle_t      s0_a;

  // biased by 92 turns so the quotient is never negative
  assign u  = {1'b0, ~angle_deg[31], angle_deg[30:19]} + BIAS_LO;
  assign qm = u * RECIP_45;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_q <= qm[26:19];
      s0_a <= angle_deg;
    end
  end

  // stage 1: remainder in [0, 360)
  logic [13:0]        qx;
  logic signed [33:0] r0;
  logic [24:0]        s1_r;

  assign qx = 14'(s0_q) * TURN_45;
  assign r0 = TURN_BIAS + 34'(s0_a) - $signed({1'b0, qx, 19'b0});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_r <= r0[24:0];
    end
  end

  // stage 2: fold into (-180, 180]
  logic signed [25:0] r1;
  logic signed [25:0] s2_r;

  assign r1 = $signed({1'b0, s1_r});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_r <= (s1_r > DEG180) ? r1 - DEG360 : r1;
    end
  end

  // stage 3: to radians
  logic signed [53:0] s3_p;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_p <= 54'(s2_r) * 54'(DEG2RAD);
    end
  end

  // stage 4: round half away from zero by 28 bits
  logic signed [53:0] rsum;
  rad_t               s4_x;

  assign rsum = s3_p + (s3_p[53] ? HALF28 - 54'sd1 : HALF28);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_x <= rsum[28+RAD_W-1:28];
    end
  end

  // stage 5: cosine argument, wrapped once
  logic signed [23:0] c;

  assign c = 24'(s4_x) + HALF_PI;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      x_sin <= s4_x;
      x_cos <= (c > PI_Q20) ? RAD_W'(c - TWO_PI) : RAD_W'(c);
    end
  end

endmodule

@@ rtl/psc_curve.sv @@
// psc_curve: nine-stage refined parabola on a q3.20 radian value
// ends in the scaled and saturated output register
// depends on psc_pkg

module psc_curve import psc_pkg::*; #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                    clk,
  input  logic [CURVE_STAGES-1:0] en,
  input  rad_t                    x,
  output trig_t                   z_out
);

  localparam logic signed [21:0] COEF_A = 22'sd1335088;
  localparam logic signed [19:0] COEF_B = 20'sd424972;
  localparam logic signed [18:0] COEF_D = 19'sd235930;
  localparam int DN = (OUT_FRAC_BITS < 20) ? 20 - OUT_FRAC_BITS : 0;
  localparam int UP = (OUT_FRAC_BITS >= 20) ? OUT_FRAC_BITS - 20 : 0;
  localparam logic signed [43:0] SAT_HI = 44'sd32767;
  localparam logic signed [43:0] SAT_LO = -44'sd32768;

  // q20 product back to q20, half away from zero
  function automatic logic signed [31:0] round20(input logic signed [51:0] v);
    logic signed [51:0] s;
    s = v + (v[51] ? 52'sd524287 : 52'sd524288);
    return s[51:20];
  endfunction

  // stage 0
  rad_t               mag_x;
  logic signed [44:0] s0_pa;
  logic signed [44:0] s0_pxx;

  assign mag_x = x[RAD_W-1] ? -x : x;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_pa  <= 45'(COEF_A) * 45'(x);
      s0_pxx <= 45'(x) * 45'(mag_x);
    end
  end

  // stage 1
  logic signed [24:0] s1_ax;
  logic signed [24:0] s1_xx;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_ax <= 25'(round20(52'(s0_pa)));
      s1_xx <= 25'(round20(52'(s0_pxx)));
    end
  end

  // stage 2
  logic signed [24:0] s2_ax;
  logic signed [44:0] s2_pb;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_ax <= s1_ax;
      s2_pb <= 45'(COEF_B) * 45'(s1_xx);
    end
  end

  // stage 3: first parabola
  logic signed [25:0] s3_y;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_y <= 26'(s2_ax) - 26'(round20(52'(s2_pb)));
    end
  end

  // stage 4
  logic signed [25:0] mag_y;
  logic signed [25:0] s4_y;
  logic signed [51:0] s4_pyy;

  assign mag_y = s3_y[25] ? -s3_y : s3_y;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_y   <= s3_y;
      s4_pyy <= 52'(s3_y) * 52'(mag_y);
    end
  end

  // stage 5: y*|y| - y
  logic signed [25:0] s5_y;
  logic signed [32:0] s5_diff;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_y    <= s4_y;
      s5_diff <= 33'(round20(s4_pyy)) - 33'(s4_y);
    end
  end

  // stage 6
  logic signed [25:0] s6_y;
  logic signed [51:0] s6_pd;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_y  <= s5_y;
      s6_pd <= 52'(COEF_D) * 52'(s5_diff);
    end
  end

  // stage 7: refined value
  logic signed [32:0] s7_z;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_z <= 33'(s6_y) + 33'(round20(s6_pd));
    end
  end

  // stage 8: rescale and saturate
  logic signed [43:0] scaled;

  generate
    if (DN > 0) begin : g_down
      localparam logic signed [33:0] HALF_DN = 34'sd1 <<< (DN - 1);
      logic signed [33:0] zs;
      always_comb begin
        zs     = 34'(s7_z) + (s7_z[32] ? HALF_DN - 34'sd1 : HALF_DN);
        scaled = 44'(zs >>> DN);
      end
    end else begin : g_up
      assign scaled = 44'(s7_z) <<< UP;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[8]) begin
      if (scaled > SAT_HI) begin
        z_out <= trig_t'(SAT_HI);
      end else if (scaled < SAT_LO) begin
        z_out <= trig_t'(SAT_LO);
      end else begin
        z_out <= scaled[TRIG_W-1:0];
      end
    end
  end

endmodule

@@ rtl/parabolic_sine_cosine_unit.sv @@
// parabolic_sine_cosine_unit: top level, angle in degrees to sine and cosine
// one item per cycle while the result side is ready or the pipeline holds a bubble
// a stage advances when it is empty or the stage after it advances
// reset clears the stage valid bits only; data registers are not reset
// depends on psc_pkg, psc_in_if, psc_out_if, psc_wrap, psc_curve

module parabolic_sine_cosine_unit import psc_pkg::*; #(
  parameter int OUT_FRAC_BITS = 15
) (
  input logic       clk,
  input logic       rst,
  psc_in_if.sink    angle,
  psc_out_if.source result
);

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] valid_next;
  logic [STAGES-1:0] en;
  rad_t              x_sin;
  rad_t              x_cos;

  // stage k moves if the result side is ready or any stage from k to the end holds a bubble
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      en[k] = result.ready || ((valid | ((STAGES'(1) << k) - STAGES'(1))) != '1);
    end
  end

  assign valid_next = (en & {valid[STAGES-2:0], angle.valid}) | (~en & valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign angle.ready  = en[0];
  assign result.valid = valid[STAGES-1];

  psc_wrap u_wrap (
    .clk       (clk),
    .en        (en[WRAP_STAGES-1:0]),
    .angle_deg (angle.angle_deg),
    .x_sin     (x_sin),
    .x_cos     (x_cos)
  );

  psc_curve #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_curve_sin (
    .clk   (clk),
    .en    (en[STAGES-1:WRAP_STAGES]),
    .x     (x_sin),
    .z_out (result.sine)
  );

  psc_curve #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_curve_cos (
    .clk   (clk),
    .en    (en[STAGES-1:WRAP_STAGES]),
    .x     (x_cos),
    .z_out (result.cosine)
  );

endmodule

@@ bench/tb_parabolic_sine_cosine_unit.sv @@
`timescale 1ns / 100ps
// tb_parabolic_sine_cosine_unit: self-checking bench for the parabolic sine/cosine unit
// predicts sine and cosine per accepted angle, checks results in order under random stalls
// depends on psc_pkg, psc_in_if, psc_out_if and parabolic_sine_cosine_unit

module tb_parabolic_sine_cosine_unit;
  import psc_pkg::*;

  localparam int     OUT_FRAC    = 15;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     HOLD_CYCLES = 100;
  localparam int     DEG_Q16     = 65536;

  localparam longint DEG360      = 64'sd23592960;
  localparam longint DEG180      = 64'sd11796480;
  localparam longint DEG2RAD_Q32 = 64'sd74961321;
  localparam longint PI_Q20      = 64'sd3294199;
  localparam longint HALF_PI_Q20 = 64'sd1647099;
  localparam longint TWO_PI_Q20  = 64'sd6588398;
  localparam longint COEF_A      = 64'sd1335088;
  localparam longint COEF_B      = 64'sd424972;
  localparam longint COEF_D      = 64'sd235930;

  typedef struct packed {
    angle_t angle;
    trig_t  sine;
    trig_t  cosine;
  } sincos_t;

  logic clk;
  logic rst;

  psc_in_if  angle_ch ();
  psc_out_if result_ch ();

  parabolic_sine_cosine_unit #(.OUT_FRAC_BITS(OUT_FRAC)) dut (
    .clk    (clk),
    .rst    (rst),
    .angle  (angle_ch),
    .result (result_ch)
  );

  sincos_t     pending_sincos[$];
  sincos_t     oldest;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          idling_on      = 1'b1;
  bit          hold_req       = 1'b0;

  // ---------------- predictor ----------------

  // right shift rounding half away from zero
  function automatic longint round_shr(longint v, int unsigned s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // refined parabola on a Q20 radian value
  function automatic longint parabola(longint x);
    longint ax, xx, y, yy;
    ax = round_shr(COEF_A * x, 20);
    xx = round_shr(x * abs64(x), 20);
    y  = ax - round_shr(COEF_B * xx, 20);
    yy = round_shr(y * abs64(y), 20);
    return y + round_shr(COEF_D * (yy - y), 20);
  endfunction

  function automatic trig_t scale_out(longint z);
    longint v;
    if (OUT_FRAC < 20) v = round_shr(z, 20 - OUT_FRAC);
    else v = z <<< (OUT_FRAC - 20);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return trig_t'(v);
  endfunction

  function automatic sincos_t sincos_of_angle(angle_t ang);
    sincos_t res;
    longint  r, rad, c;
    r = longint'(ang) % DEG360;
    if (r < 0) r += DEG360;
    // -180 wraps to +180
    if (r > DEG180) r -= DEG360;
    rad = round_shr(r * DEG2RAD_Q32, 28);
    c = rad + HALF_PI_Q20;
    if (c > PI_Q20) c -= TWO_PI_Q20;
    res.angle  = ang;
    res.sine   = scale_out(parabola(rad));
    res.cosine = scale_out(parabola(c));
    return res;
  endfunction

  // ---------------- clock, reset, timeout ----------------

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------- result side ----------------

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        result_ch.ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_sincos.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: sine %0d cosine %0d", result_ch.sine, result_ch.cosine);
      end else begin
        oldest = pending_sincos.pop_front();
        if (result_ch.sine !== oldest.sine || result_ch.cosine !== oldest.cosine) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch angle %0d: expected sine %0d cosine %0d, got sine %0d cosine %0d",
                     oldest.angle, oldest.sine, oldest.cosine, result_ch.sine, result_ch.cosine);
        end
      end
    end
  end

  // ---------------- angle side ----------------

  // valid stays high after acceptance unless a gap follows
  task automatic send_angle(input angle_t ang);
    angle_ch.valid     <= 1'b1;
    angle_ch.angle_deg <= ang;
    do @(posedge clk); while (!angle_ch.ready);
    pending_sincos.push_back(sincos_of_angle(ang));
    if (idling_on && $urandom_range(0, 3) == 0) begin
      angle_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    angle_ch.valid <= 1'b0;
    while (pending_sincos.size() != 0) @(posedge clk);
  endtask

  function automatic angle_t random_angle();
    int signed k;
    case ($urandom_range(0, 2))
      0: return angle_t'($urandom);
      1: return angle_t'($urandom_range(0, 1440 * DEG_Q16) - 720 * DEG_Q16);
      default: begin
        // near multiples of 90 degrees, where the wrap and saturation sit
        k = int'($urandom_range(0, 16)) - 8;
        return angle_t'(k * 90 * DEG_Q16 + int'($urandom_range(0, 512)) - 256);
      end
    endcase
  endfunction

  // ---------------- tests ----------------

  task automatic test_directed_angles();
    angle_t corner[] = '{
      0, 1, -1, DEG_Q16 / 2, DEG_Q16, 30 * DEG_Q16, 45 * DEG_Q16, -45 * DEG_Q16,
      60 * DEG_Q16, 90 * DEG_Q16, -90 * DEG_Q16, 135 * DEG_Q16,
      180 * DEG_Q16, -180 * DEG_Q16, 180 * DEG_Q16 + 1, -180 * DEG_Q16 - 1,
      270 * DEG_Q16, -270 * DEG_Q16, 360 * DEG_Q16, 540 * DEG_Q16, -540 * DEG_Q16,
      32'sh7FFFFFFF, 32'sh80000000
    };
    foreach (corner[i]) send_angle(corner[i]);
  endtask

  task automatic test_random_angles(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_angle(random_angle());
      if (i % 150 == 149) wait_for_results();
    end
  endtask

  // receiver holds off while angles keep coming, so the pipeline fills and stalls
  task automatic test_backpressure();
    idling_on = 1'b0;
    hold_req  = 1'b1;
    repeat (60) send_angle(random_angle());
    wait_for_results();
    idling_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    idling_on = 1'b0;
    repeat (80) send_angle(random_angle());
    wait_for_results();
  endtask

  initial begin
    rst                <= 1'b1;
    angle_ch.valid     <= 1'b0;
    angle_ch.angle_deg <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_angles();
    test_random_angles(440);
    test_backpressure();
    test_steady_stream();

    repeat (STAGES + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_sincos.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
